// ----- hdl/pae_pkg.sv -----
`timescale 1ns / 1ps
// Package for the pushdown automaton engine: command, response and table entry types,
// command kinds and configuration register indexes. Depends on nothing.
package pae_pkg;

    localparam int STATE_W    = 4;
    localparam int SYM_W      = 4;
    localparam int DEPTH_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SYMBOL = 2'd1;

    localparam logic [STATE_W-1:0] START_STATE_RESET = 4'd0;
    localparam logic [SYM_W-1:0]   INIT_SYMBOL_RESET = 4'd1;

    typedef enum logic [1:0] {
        KIND_TRANS   = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_SYMBOL  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [STATE_W-1:0] state_sel;
        logic [SYM_W-1:0]   symbol;
        logic [STATE_W-1:0] next_state;
        logic [SYM_W-1:0]   pop_symbol;
        logic [SYM_W-1:0]   push_symbol;
        logic               entry_valid;
        logic               accept_flag;
    } cmd_t;

    typedef struct packed {
        logic               matched;
        logic               accepted;
        logic               in_accept_state;
        logic [STATE_W-1:0] current_state;
        logic [DEPTH_W-1:0] stack_depth;
        logic               push_dropped;
        logic               write_refused;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] dest;
        logic [SYM_W-1:0]   need;
        logic [SYM_W-1:0]   put;
    } entry_t;

endpackage

// ----- hdl/pae_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module pae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/pushdown_automaton_engine_top.sv -----
`timescale 1ns / 1ps
// Top level of the pushdown automaton engine: table, accept flag and stack memories
// with their read-modify-write pipeline. Depends on pae_pkg and pae_ram.
//
// The engine takes a command only while no earlier command waits in the update stage:
// the transition table read for a command needs the state left by the one before it, and
// the table RAM has registered read data. A response goes from the table read through
// the update with accept flag read to the output register, and a further command may be
// taken while a response waits. After reset a clearing pass walks every entry of the
// transition table and the accept flags; commands are stalled during it, configuration
// writes are taken at any time. The top of stack lives in a register, the stack RAM
// supplies the entry below it for pops.
module pushdown_automaton_engine_top #(
    parameter int NUM_STATES        = 16,
    parameter int NUM_SYMBOLS       = 16,
    parameter int NUM_STACK_SYMBOLS = 16,
    parameter int STACK_DEPTH       = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  pae_pkg::cmd_t                    cmd,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output pae_pkg::rsp_t                    rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pae_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pae_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import pae_pkg::*;

    localparam int TBL_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int TAW       = $clog2(TBL_DEPTH);
    localparam int AAW       = $clog2(NUM_STATES);
    localparam int SAW       = $clog2(STACK_DEPTH);
    localparam int CW        = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W   = $bits(entry_t);

    // configuration
    logic [STATE_W-1:0] start_state_reg;
    logic [SYM_W-1:0]   init_sym_reg;

    // machine state
    logic [STATE_W-1:0] state_reg, state_next;
    logic [SYM_W-1:0]   top_reg, top_next;
    logic [CW-1:0]      count_reg, count_next;

    // clearing pass
    logic               clr_busy_reg;
    logic [TAW-1:0]     clr_cnt_reg;

    // pipeline
    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic               s2_valid_reg;
    logic               s2_matched_reg;
    logic [STATE_W-1:0] s2_state_reg;
    logic [DEPTH_W-1:0] s2_depth_reg;
    logic               s2_dropped_reg;
    logic               s2_refused_reg;
    logic               s2_byp_reg;
    logic               s2_byp_val_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               cmd_fire;
    logic               s1_fire;
    logic               s2_move;

    // memory ports
    logic               tbl_we;
    logic [TAW-1:0]     tbl_waddr;
    entry_t             tbl_wdata;
    logic [TAW-1:0]     tbl_raddr;
    entry_t             tbl_rdata;
    logic [ENTRY_W-1:0] tbl_rdata_raw;

    logic               acc_we;
    logic [AAW-1:0]     acc_waddr;
    logic               acc_wdata;
    logic [AAW-1:0]     acc_raddr;
    logic               acc_rdata;

    logic               stk_we;
    logic [SAW-1:0]     stk_waddr;
    logic [SYM_W-1:0]   stk_wdata;
    logic [SAW-1:0]     stk_raddr;
    logic [SYM_W-1:0]   stk_rdata;

    // update stage decisions
    logic               matched_c;
    logic               dropped_c;
    logic               refused_c;
    logic               tbl_we_c;
    entry_t             tbl_wdata_c;
    logic               acc_we_c;
    logic               stk_we_c;
    logic [SAW-1:0]     stk_waddr_c;
    logic [SYM_W-1:0]   stk_wdata_c;
    logic               wr_ok;
    logic               in_acc;
    logic [STATE_W-1:0] rd_state;

    assign cmd_stall = s1_valid_reg | clr_busy_reg;
    assign cmd_fire  = cmd_valid & ~cmd_stall;
    assign s2_move   = s2_valid_reg & (~rsp_valid_reg | ~rsp_stall);
    assign s1_fire   = s1_valid_reg & (~s2_valid_reg | s2_move);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // read addresses issued with the command
    assign rd_state  = (cmd.kind == KIND_TRANS) ? cmd.state_sel : state_reg;
    assign tbl_raddr = TAW'(TAW'(rd_state) * TAW'(NUM_SYMBOLS) + TAW'(cmd.symbol));
    assign stk_raddr = SAW'(count_reg - CW'(2));
    assign tbl_rdata = entry_t'(tbl_rdata_raw);

    assign wr_ok = (32'(s1_cmd_reg.state_sel) < NUM_STATES) &&
                   (32'(s1_cmd_reg.next_state) < NUM_STATES) &&
                   (32'(s1_cmd_reg.symbol) < NUM_SYMBOLS) &&
                   (32'(s1_cmd_reg.pop_symbol) < NUM_STACK_SYMBOLS) &&
                   (32'(s1_cmd_reg.push_symbol) < NUM_STACK_SYMBOLS);

    always_comb
    begin
        state_next  = state_reg;
        top_next    = top_reg;
        count_next  = count_reg;
        matched_c   = 1'b0;
        dropped_c   = 1'b0;
        refused_c   = 1'b0;
        tbl_we_c    = 1'b0;
        tbl_wdata_c = '0;
        acc_we_c    = 1'b0;
        stk_we_c    = 1'b0;
        stk_waddr_c = '0;
        stk_wdata_c = '0;
        case (s1_cmd_reg.kind)
            KIND_TRANS:
            begin
                if (wr_ok)
                begin
                    if (!s1_cmd_reg.entry_valid)
                    begin
                        tbl_we_c = 1'b1;
                    end
                    else if (tbl_rdata.valid)
                    begin
                        refused_c = 1'b1;
                    end
                    else
                    begin
                        tbl_we_c          = 1'b1;
                        tbl_wdata_c.valid = 1'b1;
                        tbl_wdata_c.dest  = s1_cmd_reg.next_state;
                        tbl_wdata_c.need  = s1_cmd_reg.pop_symbol;
                        tbl_wdata_c.put   = s1_cmd_reg.push_symbol;
                    end
                end
            end
            KIND_ACCEPT:
            begin
                acc_we_c = (32'(s1_cmd_reg.state_sel) < NUM_STATES);
            end
            KIND_RESTART:
            begin
                state_next = (32'(start_state_reg) < NUM_STATES) ? start_state_reg : '0;
                if (init_sym_reg != '0)
                begin
                    count_next  = CW'(1);
                    top_next    = init_sym_reg;
                    stk_we_c    = 1'b1;
                    stk_wdata_c = init_sym_reg;
                end
                else
                begin
                    count_next = '0;
                    top_next   = '0;
                end
            end
            KIND_SYMBOL:
            begin
                if ((32'(s1_cmd_reg.symbol) < NUM_SYMBOLS) && tbl_rdata.valid &&
                    (tbl_rdata.need == top_reg))
                begin
                    matched_c  = 1'b1;
                    state_next = (32'(tbl_rdata.dest) < NUM_STATES) ? tbl_rdata.dest : '0;
                    if (tbl_rdata.need != '0)
                    begin
                        if (tbl_rdata.put != '0)
                        begin
                            stk_we_c    = 1'b1;
                            stk_waddr_c = SAW'(count_reg - CW'(1));
                            stk_wdata_c = tbl_rdata.put;
                            top_next    = tbl_rdata.put;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            top_next   = (count_reg >= CW'(2)) ? stk_rdata : '0;
                        end
                    end
                    else if (tbl_rdata.put != '0)
                    begin
                        if (count_reg < CW'(STACK_DEPTH))
                        begin
                            stk_we_c    = 1'b1;
                            stk_waddr_c = SAW'(count_reg);
                            stk_wdata_c = tbl_rdata.put;
                            count_next  = count_reg + CW'(1);
                            top_next    = tbl_rdata.put;
                        end
                        else
                        begin
                            dropped_c = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // memory write muxing: clearing pass first, then update stage
    always_comb
    begin
        if (clr_busy_reg)
        begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_cnt_reg;
            tbl_wdata = '0;
            acc_we    = (32'(clr_cnt_reg) < NUM_STATES);
            acc_waddr = AAW'(clr_cnt_reg);
            acc_wdata = 1'b0;
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = INIT_SYMBOL_RESET;
        end
        else
        begin
            tbl_we    = s1_fire & tbl_we_c;
            tbl_waddr = TAW'(TAW'(s1_cmd_reg.state_sel) * TAW'(NUM_SYMBOLS) +
                             TAW'(s1_cmd_reg.symbol));
            tbl_wdata = tbl_wdata_c;
            acc_we    = s1_fire & acc_we_c;
            acc_waddr = AAW'(s1_cmd_reg.state_sel);
            acc_wdata = s1_cmd_reg.accept_flag;
            stk_we    = s1_fire & stk_we_c;
            stk_waddr = stk_waddr_c;
            stk_wdata = stk_wdata_c;
        end
    end

    assign acc_raddr = AAW'(state_next);

    pae_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (cmd_fire),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata_raw)
    );

    pae_ram #(
        .WIDTH (1),
        .DEPTH (NUM_STATES)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (s1_fire),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    pae_ram #(
        .WIDTH (SYM_W),
        .DEPTH (STACK_DEPTH)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (cmd_fire),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // control and machine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= START_STATE_RESET;
            init_sym_reg    <= INIT_SYMBOL_RESET;
            state_reg       <= START_STATE_RESET;
            top_reg         <= INIT_SYMBOL_RESET;
            count_reg       <= CW'(1);
            clr_busy_reg    <= 1'b1;
            clr_cnt_reg     <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_START_STATE: start_state_reg <= cfg_data;
                    REG_INIT_SYMBOL: init_sym_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + TAW'(1);
                if (clr_cnt_reg == TAW'(TBL_DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (s1_fire)
            begin
                state_reg <= state_next;
                top_reg   <= top_next;
                count_reg <= count_next;
            end
            if (cmd_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_move)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign in_acc = s2_byp_reg ? s2_byp_val_reg : acc_rdata;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_cmd_reg <= cmd;
        end
        if (s1_fire)
        begin
            s2_matched_reg <= matched_c;
            s2_state_reg   <= state_next;
            s2_depth_reg   <= DEPTH_W'(count_next);
            s2_dropped_reg <= dropped_c;
            s2_refused_reg <= refused_c;
            s2_byp_reg     <= acc_we_c && (AAW'(s1_cmd_reg.state_sel) == acc_raddr);
            s2_byp_val_reg <= s1_cmd_reg.accept_flag;
        end
        if (s2_move)
        begin
            rsp_reg.matched         <= s2_matched_reg;
            rsp_reg.accepted        <= s2_matched_reg & in_acc;
            rsp_reg.in_accept_state <= in_acc;
            rsp_reg.current_state   <= s2_state_reg;
            rsp_reg.stack_depth     <= s2_depth_reg;
            rsp_reg.push_dropped    <= s2_dropped_reg;
            rsp_reg.write_refused   <= s2_refused_reg;
        end
    end

`ifndef SYNTHESIS
    a_state_follows_update: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (state_reg == s2_state_reg))
        else $error("present state differs from the reported state");

    a_top_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (top_reg == '0))
        else $error("top of stack disagrees with stack count");

    a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && dropped_c) |-> (count_reg == CW'(STACK_DEPTH)))
        else $error("push dropped while the stack had room");
`endif

endmodule

// ----- tb/pae_tb_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the pushdown automaton engine: predicts one response per command
// from its own copy of the table, accept flags, stack and registers. Depends on pae_pkg.
package pae_tb_pkg;

    import pae_pkg::*;

    localparam int STACK_SLOTS = 64;

    class pda_scoreboard;

        entry_t             trans_tbl [256];
        bit                 accept_tbl [16];
        logic [STATE_W-1:0] state_now;
        logic [SYM_W-1:0]   stack_mem [STACK_SLOTS];
        logic [DEPTH_W-1:0] stack_cnt;
        logic [STATE_W-1:0] start_reg;
        logic [SYM_W-1:0]   init_reg;
        rsp_t               expected_rsp [$];
        int                 mismatches;

        function new();
            start_reg  = START_STATE_RESET;
            init_reg   = INIT_SYMBOL_RESET;
            mismatches = 0;
            for (int i = 0; i < 256; i++)
                trans_tbl[i] = '0;
            for (int i = 0; i < 16; i++)
                accept_tbl[i] = 1'b0;
            reload_stack();
        endfunction

        function void reload_stack();
            state_now = start_reg;
            for (int i = 0; i < STACK_SLOTS; i++)
                stack_mem[i] = '0;
            stack_mem[0] = init_reg;
            stack_cnt    = (init_reg != '0) ? 7'd1 : 7'd0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_START_STATE)
                start_reg = val;
            else if (idx == REG_INIT_SYMBOL)
                init_reg = val;
        endfunction

        function logic [SYM_W-1:0] stack_top();
            return (stack_cnt > 0) ? stack_mem[stack_cnt - 1] : '0;
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        function rsp_t step_automaton(cmd_t c);
            rsp_t             r;
            entry_t           e;
            logic [SYM_W-1:0] top;
            r   = '0;
            top = stack_top();
            case (c.kind)
                KIND_TRANS:
                begin
                    if (!c.entry_valid)
                        trans_tbl[{c.state_sel, c.symbol}] = '0;
                    else if (trans_tbl[{c.state_sel, c.symbol}].valid)
                        r.write_refused = 1'b1;
                    else
                    begin
                        e.valid = 1'b1;
                        e.dest  = c.next_state;
                        e.need  = c.pop_symbol;
                        e.put   = c.push_symbol;
                        trans_tbl[{c.state_sel, c.symbol}] = e;
                    end
                end
                KIND_ACCEPT:
                    accept_tbl[c.state_sel] = c.accept_flag;
                KIND_RESTART:
                    reload_stack();
                KIND_SYMBOL:
                begin
                    e = trans_tbl[{state_now, c.symbol}];
                    if (e.valid && e.need == top)
                    begin
                        r.matched = 1'b1;
                        state_now = e.dest;
                        if (e.need != '0 && stack_cnt > 0)
                            stack_cnt = stack_cnt - 7'd1;
                        if (e.put != '0)
                        begin
                            if (stack_cnt < STACK_SLOTS)
                            begin
                                stack_mem[stack_cnt] = e.put;
                                stack_cnt = stack_cnt + 7'd1;
                            end
                            else
                                r.push_dropped = 1'b1;
                        end
                        r.accepted = accept_tbl[state_now];
                    end
                end
                default:
                begin
                end
            endcase
            r.in_accept_state = accept_tbl[state_now];
            r.current_state   = state_now;
            r.stack_depth     = stack_cnt;
            return r;
        endfunction

        function void note_cmd(cmd_t c);
            expected_rsp = {expected_rsp, step_automaton(c)};
        endfunction

        function string show(rsp_t r);
            return $sformatf({"matched=%0b accepted=%0b in_accept=%0b state=%0d ",
                              "depth=%0d dropped=%0b refused=%0b"},
                r.matched, r.accepted, r.in_accept_state, r.current_state, r.stack_depth,
                r.push_dropped, r.write_refused);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        function void check_rsp(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                flag({"response with nothing expected: ", show(got)});
                return;
            end
            want = expected_rsp.pop_front();
            if (got.matched !== want.matched || got.accepted !== want.accepted ||
                got.in_accept_state !== want.in_accept_state ||
                got.current_state !== want.current_state ||
                got.stack_depth !== want.stack_depth ||
                got.push_dropped !== want.push_dropped ||
                got.write_refused !== want.write_refused)
                flag({"expected ", show(want), " got ", show(got)});
        endfunction

    endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the pushdown automaton engine: directed and random commands under
// several stall patterns, register writes between phases. Depends on pae_pkg, pae_tb_pkg.
module tb_top;

    import pae_pkg::*;
    import pae_tb_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cmd_valid;
    logic                  cmd_stall;
    cmd_t                  cmd;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pda_scoreboard sb;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            hold_len;
    int            hold_left = 0;
    bit            hold_taken = 1'b0;

    pushdown_automaton_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // check the response transaction, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_rsp(rsp);
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (hold_len > 0 && !hold_taken)
        begin
            hold_left  = hold_len - 1;
            hold_taken = 1'b1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic cmd_t cmd_item(input kind_t k, input logic [3:0] sel, sym, nxt, pop,
                                      push, input logic ev, af);
        cmd_t c;
        c.kind        = k;
        c.state_sel   = sel;
        c.symbol      = sym;
        c.next_state  = nxt;
        c.pop_symbol  = pop;
        c.push_symbol = push;
        c.entry_valid = ev;
        c.accept_flag = af;
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] pick_stack_sym();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return sb.init_reg;
        if (r == 2)
            return SYM_W'($urandom_range(0, 15));
        return SYM_W'($urandom_range(1, 3));
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t                    c;
        logic [$bits(cmd_t)-1:0] raw;
        logic [SYM_W-1:0]        hits [$];
        entry_t                  e;
        int                      r;
        raw = $bits(cmd_t)'($urandom);
        c   = raw;
        r   = $urandom_range(0, 99);
        if (r < 12)
        begin
            c.kind = KIND_TRANS;
            if ($urandom_range(0, 9) < 6)
                c.state_sel = sb.state_now;
            c.pop_symbol = ($urandom_range(0, 1) == 1) ? sb.stack_top() : pick_stack_sym();
            if ($urandom_range(0, 9) < 7)
                c.push_symbol = pick_stack_sym();
            c.entry_valid = ($urandom_range(0, 9) >= 3);
        end
        else if (r < 17)
            c.kind = KIND_ACCEPT;
        else if (r < 21)
            c.kind = KIND_RESTART;
        else
        begin
            c.kind = KIND_SYMBOL;
            for (int s = 0; s < 16; s++)
            begin
                e = sb.trans_tbl[{sb.state_now, SYM_W'(s)}];
                if (e.valid && e.need == sb.stack_top())
                    hits = {hits, SYM_W'(s)};
            end
            if (hits.size() > 0 && $urandom_range(0, 99) < 85)
                c.symbol = hits[$urandom_range(0, hits.size() - 1)];
        end
        return c;
    endfunction

    task automatic send_cmd(input cmd_t c);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_cmd(c);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        logic [3:0] start_val;
        logic [3:0] init_val;
        sb             = new();
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd            = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_cmd(cmd_item(KIND_SYMBOL,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 1'b0));
        send_cmd(cmd_item(KIND_ACCEPT,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 1'b1));
        send_cmd(cmd_item(KIND_ACCEPT,  4'd15, 4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 1'b1));
        send_cmd(cmd_item(KIND_TRANS,   4'd0,  4'd0,  4'd15, 4'd1,  4'd15, 1'b1, 1'b0));
        send_cmd(cmd_item(KIND_TRANS,   4'd0,  4'd0,  4'd2,  4'd3,  4'd4,  1'b1, 1'b0));
        send_cmd(cmd_item(KIND_SYMBOL,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 1'b0));
        send_cmd(cmd_item(KIND_TRANS,   4'd15, 4'd15, 4'd0,  4'd15, 4'd0,  1'b1, 1'b0));
        send_cmd(cmd_item(KIND_SYMBOL,  4'd0,  4'd15, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0));
        send_cmd(cmd_item(KIND_SYMBOL,  4'd0,  4'd15, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0));
        send_cmd(cmd_item(KIND_TRANS,   4'd0,  4'd5,  4'd3,  4'd0,  4'd2,  1'b1, 1'b0));
        send_cmd(cmd_item(KIND_SYMBOL,  4'd0,  4'd5,  4'd0,  4'd0,  4'd0,  1'b0, 1'b0));
        send_cmd(cmd_item(KIND_TRANS,   4'd3,  4'd10, 4'd3,  4'd7,  4'd7,  1'b1, 1'b0));
        send_cmd(cmd_item(KIND_SYMBOL,  4'd0,  4'd10, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0));
        send_cmd(cmd_item(KIND_TRANS,   4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 1'b0));
        send_cmd(cmd_item(KIND_TRANS,   4'd9,  4'd9,  4'd0,  4'd0,  4'd0,  1'b0, 1'b0));
        send_cmd(cmd_item(KIND_RESTART, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 1'b0));
        send_cmd(cmd_item(KIND_SYMBOL,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 1'b0));
        send_cmd(cmd_item(KIND_TRANS,   4'd0,  4'd0,  4'd6,  4'd1,  4'd0,  1'b1, 1'b0));
        send_cmd(cmd_item(KIND_SYMBOL,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 1'b0));
        send_cmd(cmd_item(KIND_ACCEPT,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 1'b0));
        send_cmd(cmd_item(KIND_RESTART, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 1'b0));

        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            repeat (8) @(posedge clk);
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    start_val      = 4'd15;
                    init_val       = 4'd15;
                end
                1:
                begin
                    send_idle_pct  = 69;
                    recv_stall_pct = 0;
                    start_val      = 4'd0;
                    init_val       = 4'd0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 69;
                    start_val      = 4'($urandom_range(0, 15));
                    init_val       = 4'($urandom_range(1, 15));
                end
                default:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                    start_val      = 4'($urandom_range(0, 15));
                    init_val       = 4'($urandom_range(0, 15));
                end
            endcase
            write_reg(REG_START_STATE, start_val);
            write_reg(REG_INIT_SYMBOL, init_val);
            send_cmd(cmd_item(KIND_RESTART, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0));
            for (int n = 0; n < 256; n++)
            begin
                // hold the response side long enough to back up the command side
                if (phase == 0 && n == 100)
                    hold_len = 60;
                if (phase == 2 && n == 120)
                    wait_drained();
                send_cmd(random_cmd());
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
